[rtl/core/fps_pkg.sv]
package fps_pkg;

    // Fixed field and state widths
    localparam int PHASE_W = 8;
    localparam int LEN_W   = 7;
    localparam int TICK_W  = 8;
    localparam int SUM_W   = 18;
    localparam int DIFF_W  = 10;
    localparam int MAG_W   = SUM_W - 1;

    // Word operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MSG  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CYCLE_LENGTH = 1'b0;
    localparam logic CFG_FLASH_LENGTH = 1'b1;

    // Configuration reset values
    localparam logic [LEN_W-1:0] CYCLE_LENGTH_RST = 7'd64;
    localparam logic [LEN_W-1:0] FLASH_LENGTH_RST = 7'd8;

    // Top-level control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Divide request from the control path to the serial divider
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } div_req_t;

endpackage

[rtl/core/fps_div.sv]
module fps_div #(
    parameter int DVS_W = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fps_pkg::div_req_t                   req,
    input  logic [DVS_W-1:0]                    divisor,
    output logic                                done,
    output logic signed [fps_pkg::PHASE_W-1:0]  quot
);

    localparam int CNT_W = $clog2(fps_pkg::MAG_W + 1);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [DVS_W-1:0]               rem_reg;
    logic [fps_pkg::MAG_W-1:0]      quo_reg;
    logic [DVS_W-1:0]               dvs_reg;
    logic                           neg_reg;
    logic [fps_pkg::PHASE_W-1:0]    res_reg;

    logic [DVS_W+1:0]               trial;
    logic                           trial_ok;
    logic [DVS_W-1:0]               rem_step;
    logic [fps_pkg::PHASE_W-1:0]    res_sat;

    // Trial subtract of the divisor from the shifted remainder, one quotient bit a cycle
    assign trial    = {1'b0, rem_reg, quo_reg[fps_pkg::MAG_W-1]} - {2'b00, dvs_reg};
    assign trial_ok = ~trial[DVS_W+1];
    assign rem_step = trial_ok ? trial[DVS_W-1:0]
                               : {rem_reg[DVS_W-2:0], quo_reg[fps_pkg::MAG_W-1]};

    // Apply the sign and clamp to the signed phase range
    always_comb begin
        if (neg_reg) begin
            if (quo_reg > fps_pkg::MAG_W'(128)) begin
                res_sat = 8'h80;
            end else begin
                res_sat = 8'd0 - quo_reg[fps_pkg::PHASE_W-1:0];
            end
        end else begin
            if (quo_reg > fps_pkg::MAG_W'(127)) begin
                res_sat = 8'h7F;
            end else begin
                res_sat = quo_reg[fps_pkg::PHASE_W-1:0];
            end
        end
    end

    // Sequence control: load, iterate, finish
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(fps_pkg::MAG_W);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift the dividend through the remainder and collect quotient bits
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.mag;
            dvs_reg <= divisor;
            neg_reg <= req.neg;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[fps_pkg::MAG_W-2:0], trial_ok};
        end
        if (busy_reg && cnt_reg == '0) begin
            res_reg <= res_sat;
        end
    end

    assign done = done_reg;
    assign quot = $signed(res_reg);

endmodule

[rtl/core/flash_phase_sync.sv]
// Flash phase sync: keeps a local flash-cycle phase that advances on each tick word
// (op = 0) and gathers neighbour phase offsets from message words (op = 1). Every
// accepted word returns exactly one result word. Ticks that do not end a cycle and
// all messages let the block take the next word right away unless the result output
// is held back by m_ready. A tick that ends a cycle with at least one message gathered
// runs the bit-serial divider that averages the offsets: one quotient bit per cycle
// over the 17-bit sum magnitude; no new word is taken before that result is loaded.
// A cycle-end tick with no messages restarts at phase zero. The cycle_length (index 0)
// and flash_length (index 1) registers are written through the cfg port and take
// effect for the next word.
module flash_phase_sync #(
    parameter int MAX_MESSAGES = 255
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [fps_pkg::LEN_W-1:0]       cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [fps_pkg::PHASE_W-1:0]     s_neighbour_phase,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_light_on,
    output logic                            m_flash_start,
    output logic [fps_pkg::PHASE_W-1:0]     m_phase_byte
);

    localparam int CNT_RAW = $clog2(MAX_MESSAGES + 1);
    localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGES);

    fps_pkg::state_t                        state_reg, state_next;
    logic [fps_pkg::LEN_W-1:0]              cl_reg, fl_reg;
    logic signed [fps_pkg::PHASE_W-1:0]     lp_reg, lp_next;
    logic [fps_pkg::TICK_W-1:0]             ticks_reg, ticks_next;
    logic signed [fps_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]                       count_reg, count_next;
    logic                                   light_reg, light_next;
    logic                                   m_valid_reg, m_valid_next;
    logic                                   m_light_on_reg;
    logic                                   m_flash_start_reg;
    logic [fps_pkg::PHASE_W-1:0]            m_phase_byte_reg;

    logic                                   out_load;
    logic                                   out_light;
    logic                                   out_flash;
    logic [fps_pkg::PHASE_W-1:0]            out_phase;

    logic signed [fps_pkg::PHASE_W:0]       phase_inc;
    logic                                   wrap_end;
    logic [fps_pkg::TICK_W-1:0]             ticks_inc;
    logic signed [fps_pkg::DIFF_W-1:0]      diff, diff_a, diff_b, cl_s;
    logic signed [fps_pkg::DIFF_W:0]        cl_w, cl_neg_w;
    logic signed [fps_pkg::SUM_W-1:0]       sum_add;
    logic                                   accept;

    fps_pkg::div_req_t                      div_req;
    logic                                   div_done;
    logic signed [fps_pkg::PHASE_W-1:0]     div_quot;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == fps_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // Tick arithmetic
    assign phase_inc = $signed({lp_reg[fps_pkg::PHASE_W-1], lp_reg}) + 9'sd1;
    assign wrap_end  = phase_inc >= $signed({2'b00, cl_reg});
    assign ticks_inc = (ticks_reg == 8'hFF) ? ticks_reg : ticks_reg + 8'd1;

    // Neighbour offset, wrapped once toward plus or minus half a cycle
    assign cl_s     = $signed({3'b000, cl_reg});
    assign cl_w     = $signed({4'b0000, cl_reg});
    assign cl_neg_w = 11'sd0 - cl_w;
    assign diff     = $signed({2'b00, s_neighbour_phase})
                    - $signed({{2{lp_reg[fps_pkg::PHASE_W-1]}}, lp_reg});
    assign diff_a   = ($signed({diff, 1'b0}) > cl_w) ? diff - cl_s : diff;
    assign diff_b   = ($signed({diff_a, 1'b0}) < cl_neg_w) ? diff_a + cl_s : diff_a;
    assign sum_add  = sum_reg
                    + $signed({{(fps_pkg::SUM_W-fps_pkg::DIFF_W){diff_b[fps_pkg::DIFF_W-1]}},
                               diff_b});

    // Divide request: magnitude and sign of the offset sum
    always_comb begin
        div_req.neg = sum_reg[fps_pkg::SUM_W-1];
        if (sum_reg[fps_pkg::SUM_W-1]) begin
            div_req.mag = fps_pkg::MAG_W'(-sum_reg);
        end else begin
            div_req.mag = fps_pkg::MAG_W'(sum_reg);
        end
        div_req.start = accept && (s_op == fps_pkg::OP_TICK) && wrap_end
                        && (count_reg != '0);
    end

    // Next state and result word
    always_comb begin
        state_next = state_reg;
        lp_next    = lp_reg;
        ticks_next = ticks_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        light_next = light_reg;
        out_load   = 1'b0;
        out_light  = light_reg;
        out_flash  = 1'b0;
        out_phase  = lp_reg;
        case (state_reg)
            fps_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_op == fps_pkg::OP_TICK) begin
                        if (wrap_end) begin
                            light_next = 1'b1;
                            ticks_next = '0;
                            sum_next   = '0;
                            count_next = '0;
                            if (count_reg == '0) begin
                                lp_next   = '0;
                                out_load  = 1'b1;
                                out_light = 1'b1;
                                out_flash = 1'b1;
                                out_phase = '0;
                            end else begin
                                state_next = fps_pkg::ST_DIV;
                            end
                        end else begin
                            lp_next    = phase_inc[fps_pkg::PHASE_W-1:0];
                            ticks_next = ticks_inc;
                            if (ticks_inc > {1'b0, fl_reg}) begin
                                light_next = 1'b0;
                            end
                            out_load  = 1'b1;
                            out_light = light_next;
                            out_phase = phase_inc[fps_pkg::PHASE_W-1:0];
                        end
                    end else begin
                        // Drop the message once the count is full
                        if (count_reg != CNT_MAX) begin
                            sum_next   = sum_add;
                            count_next = count_reg + 1'b1;
                        end
                        out_load = 1'b1;
                    end
                end
            end
            fps_pkg::ST_DIV: begin
                if (div_done) begin
                    lp_next    = div_quot;
                    state_next = fps_pkg::ST_EMIT;
                end
            end
            fps_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    out_flash  = 1'b1;
                    state_next = fps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fps_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fps_pkg::ST_IDLE;
            cl_reg      <= fps_pkg::CYCLE_LENGTH_RST;
            fl_reg      <= fps_pkg::FLASH_LENGTH_RST;
            lp_reg      <= '0;
            ticks_reg   <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            light_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lp_reg      <= lp_next;
            ticks_reg   <= ticks_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            light_reg   <= light_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fps_pkg::CFG_CYCLE_LENGTH: cl_reg <= cfg_data;
                    fps_pkg::CFG_FLASH_LENGTH: fl_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Load the output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_light_on_reg    <= out_light;
            m_flash_start_reg <= out_flash;
            m_phase_byte_reg  <= out_phase;
        end
    end

    fps_div #(
        .DVS_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .divisor (count_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign m_valid       = m_valid_reg;
    assign m_light_on    = m_light_on_reg;
    assign m_flash_start = m_flash_start_reg;
    assign m_phase_byte  = m_phase_byte_reg;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("message count above limit");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == fps_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_flash_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_flash_start_reg) |-> m_light_on_reg)
        else $error("flash start word without light on");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |=> state_reg == fps_pkg::ST_DIV)
        else $error("divide started without entering divide state");
`endif

endmodule

[bench/flash_phase_sync_tb.sv]
`timescale 1ns / 1ps

module flash_phase_sync_tb;

    localparam int CLK_PERIOD      = 10;
    localparam int MAX_MESSAGES    = 255;
    localparam int DRAIN_CYCLES    = 32;
    localparam int CYCLE_LIMIT     = 600_000;
    localparam int NUM_PHASES      = 10;
    localparam int WORDS_PER_PHASE = 130;
    localparam int FLOOD_MESSAGES  = MAX_MESSAGES + 2;

    typedef struct packed {
        logic                        op;
        logic [fps_pkg::PHASE_W-1:0] nb;
    } sync_word_t;

    typedef struct packed {
        logic                        light;
        logic                        start;
        logic [fps_pkg::PHASE_W-1:0] phase;
    } flash_word_t;

    typedef struct packed {
        logic                      idx;
        logic [fps_pkg::LEN_W-1:0] val;
    } reg_write_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_RUNS
    } rx_mode_t;

    // DUT ports
    logic                        aclk              = 1'b0;
    logic                        aresetn           = 1'b0;
    logic                        cfg_valid         = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_index         = fps_pkg::CFG_CYCLE_LENGTH;
    logic [fps_pkg::LEN_W-1:0]   cfg_data          = '0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic                        s_op              = fps_pkg::OP_TICK;
    logic [fps_pkg::PHASE_W-1:0] s_neighbour_phase = '0;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic                        m_light_on;
    logic                        m_flash_start;
    logic [fps_pkg::PHASE_W-1:0] m_phase_byte;

    // Stimulus and expectation stores
    sync_word_t  pending_words[$];
    reg_write_t  reg_write_q[$];
    flash_word_t flash_expect_q[$];

    int words_queued     = 0;
    int words_accepted   = 0;
    int results_seen     = 0;
    int regs_queued      = 0;
    int regs_written     = 0;
    int error_count      = 0;
    int cycle_count      = 0;
    int msgs_sent        = 0;
    int dropped_msgs     = 0;
    int flashes          = 0;
    int averaged_flashes = 0;

    // Predictor state
    logic [fps_pkg::LEN_W-1:0] cycle_len = fps_pkg::CYCLE_LENGTH_RST;
    logic [fps_pkg::LEN_W-1:0] flash_len = fps_pkg::FLASH_LENGTH_RST;
    int   phase_now   = 0;
    int   ticks_since = 0;
    int   offset_acc  = 0;
    int   msg_count   = 0;
    logic lamp        = 1'b0;

    // Sender and receiver pacing
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       mode_left  = 0;
    int       stall_left = 0;

    flash_phase_sync #(
        .MAX_MESSAGES(MAX_MESSAGES)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_neighbour_phase(s_neighbour_phase),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_light_on       (m_light_on),
        .m_flash_start    (m_flash_start),
        .m_phase_byte     (m_phase_byte)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Advance the local oscillator by one word and return the result it yields
    function automatic flash_word_t advance_phase(input logic op,
                                                  input logic [fps_pkg::PHASE_W-1:0] nb);
        flash_word_t w;
        int next_phase;
        int diff;
        int cl;
        cl = int'(cycle_len);
        w.start = 1'b0;
        if (op == fps_pkg::OP_TICK) begin
            next_phase = phase_now + 1;
            if (next_phase >= cl) begin
                // end of cycle: flash and restart at the mean offset, or at zero with no messages
                lamp = 1'b1;
                w.start = 1'b1;
                ticks_since = 0;
                flashes++;
                if (msg_count == 0) begin
                    phase_now = 0;
                end else begin
                    phase_now = offset_acc / msg_count;
                    if (phase_now > 127) phase_now = 127;
                    if (phase_now < -128) phase_now = -128;
                    averaged_flashes++;
                end
                offset_acc = 0;
                msg_count = 0;
            end else begin
                phase_now = next_phase;
                if (ticks_since < 255) ticks_since++;
                if (ticks_since > int'(flash_len)) lamp = 1'b0;
            end
        end else if (msg_count < MAX_MESSAGES) begin
            // wrap the offset once each way toward half a cycle
            diff = int'(nb) - phase_now;
            if (2 * diff > cl) diff -= cl;
            if (2 * diff < -cl) diff += cl;
            offset_acc += diff;
            msg_count++;
        end else begin
            dropped_msgs++;
        end
        w.light = lamp;
        w.phase = phase_now[fps_pkg::PHASE_W-1:0];
        return w;
    endfunction

    function automatic void queue_word(input logic op, input logic [fps_pkg::PHASE_W-1:0] nb);
        sync_word_t w;
        w.op = op;
        w.nb = nb;
        pending_words.push_back(w);
        words_queued++;
        if (op == fps_pkg::OP_MSG) msgs_sent++;
    endfunction

    task automatic write_reg(input logic idx, input logic [fps_pkg::LEN_W-1:0] val);
        reg_write_t w;
        w.idx = idx;
        w.val = val;
        reg_write_q.push_back(w);
        regs_queued++;
        while (regs_written != regs_queued) @(posedge aclk);
    endtask

    // Hold until every word is in and every result is out, then let the divider settle
    task automatic wait_idle();
        while (words_accepted != words_queued || flash_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Driver: register writes and input words
    always @(posedge aclk) begin : drive_words
        sync_word_t w;
        reg_write_t r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                flash_expect_q.push_back(advance_phase(s_op, s_neighbour_phase));
                words_accepted++;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fps_pkg::CFG_CYCLE_LENGTH) cycle_len = cfg_data;
                else flash_len = cfg_data;
                regs_written++;
            end

            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() != 0) begin
                    r = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= r.idx;
                    cfg_data  <= r.val;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end

            // send in bursts, with a random gap (sometimes none) after each
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_valid           <= 1'b1;
                    s_op              <= w.op;
                    s_neighbour_phase <= w.nb;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest expectation
    always @(posedge aclk) begin : watch_results
        flash_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (flash_expect_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                end else begin
                    want = flash_expect_q.pop_front();
                    if (m_light_on != want.light)
                        report_error($sformatf("result %0d light_on %0b, want %0b",
                                               results_seen, m_light_on, want.light));
                    if (m_flash_start != want.start)
                        report_error($sformatf("result %0d flash_start %0b, want %0b",
                                               results_seen, m_flash_start, want.start));
                    if (m_phase_byte != want.phase)
                        report_error($sformatf("result %0d phase_byte %02h, want %02h",
                                               results_seen, m_phase_byte, want.phase));
                end
            end

            // switch stall pattern now and then
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 2));
                mode_left <= $urandom_range(20, 300);
            end else begin
                mode_left <= mode_left - 1;
            end

            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    if (stall_left == 0) begin
                        m_ready    <= ~m_ready;
                        stall_left <= $urandom_range(1, 25);
                    end else begin
                        stall_left <= stall_left - 1;
                    end
                end
            endcase
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d words accepted",
                     cycle_count, words_accepted, words_queued);
            $display("flash_phase_sync test failed");
            $finish;
        end
    end

    initial begin : run_test
        int p;
        int k;
        int cl;
        int fl;
        int msg_pct;
        logic [fps_pkg::PHASE_W-1:0] nb;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset register values, extreme neighbour phases
        queue_word(fps_pkg::OP_MSG, 8'h00);
        queue_word(fps_pkg::OP_MSG, 8'hFF);
        queue_word(fps_pkg::OP_MSG, 8'h80);
        queue_word(fps_pkg::OP_TICK, 8'hA5);
        queue_word(fps_pkg::OP_TICK, 8'h5A);
        wait_idle();

        // directed: cycle length 2, light off right after the flash
        write_reg(fps_pkg::CFG_CYCLE_LENGTH, 7'd2);
        write_reg(fps_pkg::CFG_FLASH_LENGTH, 7'd0);
        queue_word(fps_pkg::OP_TICK, 8'h00);
        queue_word(fps_pkg::OP_TICK, 8'hFF);   // cycle end with no messages
        queue_word(fps_pkg::OP_MSG, 8'hFF);    // offset wraps down
        queue_word(fps_pkg::OP_MSG, 8'hFF);
        queue_word(fps_pkg::OP_TICK, 8'h00);
        queue_word(fps_pkg::OP_TICK, 8'h00);   // average saturates high, phase 127
        queue_word(fps_pkg::OP_MSG, 8'h00);    // offset wraps up from the top phase
        queue_word(fps_pkg::OP_MSG, 8'h80);
        queue_word(fps_pkg::OP_TICK, 8'hFF);   // tick from 127 always flashes
        queue_word(fps_pkg::OP_TICK, 8'h00);
        queue_word(fps_pkg::OP_MSG, 8'h00);
        queue_word(fps_pkg::OP_MSG, 8'h00);
        queue_word(fps_pkg::OP_MSG, 8'h01);
        queue_word(fps_pkg::OP_TICK, 8'h00);   // climb back from a negative phase
        queue_word(fps_pkg::OP_TICK, 8'h00);
        queue_word(fps_pkg::OP_TICK, 8'h00);
        queue_word(fps_pkg::OP_TICK, 8'h00);
        wait_idle();

        // random phases over a spread of register settings
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cl = 64;  fl = 8;   end
                1: begin cl = 2;   fl = 0;   end
                2: begin cl = 127; fl = 127; end
                3: begin cl = 1;   fl = 3;   end
                4: begin cl = 0;   fl = 0;   end
                5: begin cl = 126; fl = 127; end
                6: begin cl = 5;   fl = 1;   end
                default: begin
                    cl = $urandom_range(0, 127);
                    fl = $urandom_range(0, 127);
                end
            endcase
            write_reg(fps_pkg::CFG_CYCLE_LENGTH, fps_pkg::LEN_W'(cl));
            write_reg(fps_pkg::CFG_FLASH_LENGTH, fps_pkg::LEN_W'(fl));

            // fill the message count past full, then run the cycle out
            if (p == 2) begin
                for (k = 0; k < FLOOD_MESSAGES; k++) begin
                    queue_word(fps_pkg::OP_MSG, 8'($urandom_range(0, 255)));
                end
                for (k = 0; k < 130; k++) begin
                    queue_word(fps_pkg::OP_TICK, 8'($urandom_range(0, 255)));
                end
            end

            msg_pct = $urandom_range(5, 50);
            for (k = 0; k < WORDS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < msg_pct) begin
                    case ($urandom_range(0, 3))
                        0:       nb = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                        1:       nb = 8'($urandom_range(0, cl));
                        default: nb = 8'($urandom_range(0, 255));
                    endcase
                    queue_word(fps_pkg::OP_MSG, nb);
                end else begin
                    queue_word(fps_pkg::OP_TICK, 8'($urandom_range(0, 255)));
                end
            end
            wait_idle();
        end

        if (flash_expect_q.size() != 0)
            report_error($sformatf("%0d results never arrived", flash_expect_q.size()));

        $display("ran %0d words (%0d messages, %0d dropped at full count), %0d register writes",
                 words_accepted, msgs_sent, dropped_msgs, regs_written);
        $display("saw %0d flashes, %0d of them restarted from an averaged offset",
                 flashes, averaged_flashes);
        if (error_count == 0) begin
            $display("flash_phase_sync test passed");
        end else begin
            $display("flash_phase_sync test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/fps_pkg.sv
rtl/core/fps_div.sv
rtl/core/flash_phase_sync.sv
bench/flash_phase_sync_tb.sv
